FILE: rtl/strain_flex_sensor_evaluator_assert.svh
// ----------------------------------------------------------------------------
// Strain flex sensor evaluator assertion macros
// Shared concurrent assertion forms for the evaluator RTL.
// ----------------------------------------------------------------------------
`ifndef STRAIN_FLEX_SENSOR_EVALUATOR_ASSERT_SVH
`define STRAIN_FLEX_SENSOR_EVALUATOR_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SFSE_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sfse assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define SFSE_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sfse assertion failed");

`endif

FILE: rtl/sfse_pkg.sv
// ----------------------------------------------------------------------------
// Strain flex sensor evaluator package
// Payload, configuration and control types, codes and the tangent table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package sfse_pkg;

   localparam int CHANNELS   = 4;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 12;
   localparam int DIV_NUM_W  = 32;
   localparam int DIV_DEN_W  = 16;
   localparam int DIV_CNT_W  = 6;

   localparam logic [CSR_IDX_W-1:0] CSR_FULL_SCALE = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_YELLOW     = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_RED        = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SPAN       = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN_A     = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN_B     = 3'd5;

   localparam logic [1:0] MODE_SAMPLE = 2'd0;
   localparam logic [1:0] MODE_ZERO   = 2'd1;
   localparam logic [1:0] MODE_EVAL   = 2'd2;

   localparam logic [1:0] LEVEL_GREEN  = 2'd0;
   localparam logic [1:0] LEVEL_YELLOW = 2'd1;
   localparam logic [1:0] LEVEL_RED    = 2'd2;

   localparam logic [15:0] PERCENT_MAX = 16'h7fff;
   localparam logic [15:0] PERCENT_MIN = 16'h8000;

   localparam logic [9:0] TAN512 [0:45] = '{
      10'd0,   10'd9,   10'd18,  10'd27,  10'd36,  10'd45,  10'd54,  10'd63,
      10'd72,  10'd81,  10'd90,  10'd100, 10'd109, 10'd118, 10'd128, 10'd137,
      10'd147, 10'd157, 10'd166, 10'd176, 10'd186, 10'd197, 10'd207, 10'd217,
      10'd228, 10'd239, 10'd250, 10'd261, 10'd272, 10'd284, 10'd296, 10'd308,
      10'd320, 10'd332, 10'd345, 10'd359, 10'd372, 10'd386, 10'd400, 10'd415,
      10'd430, 10'd445, 10'd461, 10'd477, 10'd494, 10'd512
   };

   typedef struct packed {
      logic [1:0] mode;
      logic [9:0] sample_flex_a;
      logic [9:0] sample_flex_b;
      logic [9:0] sample_stretch_a;
      logic [9:0] sample_stretch_b;
   } req_type;

   typedef struct packed {
      logic [15:0]        location_q8;
      logic [13:0]        depth_q8;
      logic signed [15:0] stretch_percent;
      logic [1:0]         load_level;
      logic               angle_fault;
   } rsp_type;

   typedef struct packed {
      logic [11:0] stretch_full_scale;
      logic [9:0]  yellow_threshold;
      logic [9:0]  red_threshold;
      logic [7:0]  span_length_cm;
      logic [7:0]  gain_a_tenths;
      logic [7:0]  gain_b_tenths;
   } cfg_type;

   typedef struct packed {
      logic sample_rd;
      logic sample_upd;
      logic avg_start;
      logic zero_capture;
   } lane_ctrl_type;

   function automatic logic [9:0] tan_lookup(input logic [5:0] idx);
      logic [9:0] val;
      val = 10'd0;
      if (idx < 6'd46) begin
         val = TAN512[idx];
      end
      return val;
   endfunction

endpackage

`default_nettype wire

FILE: rtl/strain_flex_sensor_evaluator.sv
// ----------------------------------------------------------------------------
// Strain flex sensor evaluator
// Four sensor lanes keep sliding sample windows; an evaluation merges their
// averages into stretch percent, load level, span location and depth.
//
// Transactions enter on req_valid/req_ready and carry a mode. A sample
// transaction registers its sample, then writes one window slot per lane in
// S_SAMPLE. A zero transaction copies the lane averages into the zero
// registers. Neither produces a result. An evaluate transaction presents its
// result on rsp_valid, and the next transaction is accepted only once that
// result is in the output register: the lanes average their running sums
// with a reciprocal multiply, then the merge stage runs three 32-step
// divisions on one shared divider.
// One transaction is processed at a time; req_ready is high while the block
// is idle, also while a result still waits on rsp_valid/rsp_ready.
// When the receiver stalls, a finished evaluation holds until the output
// register is free. Reset restores the register defaults and empties the
// sample windows through a fill count; no clearing pass is needed. The user
// writes configuration via csr_we/csr_index/csr_wdata while idle (unenforced).
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "strain_flex_sensor_evaluator_assert.svh"

module strain_flex_sensor_evaluator #(
   parameter int WINDOW      = 8,
   parameter int SAMPLE_BITS = 10
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_valid,
   output logic                                    req_ready,
   input  wire sfse_pkg::req_type                  req_data,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_ready,
   output sfse_pkg::rsp_type                       rsp_data,
   input  wire logic                               csr_we,
   input  wire logic [sfse_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [sfse_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   typedef enum logic [4:0] {
      S_IDLE   = 5'b00001,
      S_SAMPLE = 5'b00010,
      S_AVG    = 5'b00100,
      S_MERGE  = 5'b01000,
      S_OUT    = 5'b10000
   } state_type;

   state_type                 state_ff, state_in;
   sfse_pkg::cfg_type         cfg_ff, cfg_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   sfse_pkg::rsp_type         rsp_data_ff, rsp_data_in;
   sfse_pkg::lane_ctrl_type   lane_ctrl;
   logic [SAMPLE_BITS-1:0]    lane_sample [sfse_pkg::CHANNELS];
   logic [SAMPLE_BITS-1:0]    lane_avg    [sfse_pkg::CHANNELS];
   logic [SAMPLE_BITS-1:0]    lane_zero   [sfse_pkg::CHANNELS];
   logic [sfse_pkg::CHANNELS-1:0] lane_busy;
   logic                      accept;
   logic                      merge_start, merge_done;
   sfse_pkg::rsp_type         merge_result;
   logic                      out_stalled;

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;

   assign lane_sample[0] = SAMPLE_BITS'(req_data.sample_flex_a);
   assign lane_sample[1] = SAMPLE_BITS'(req_data.sample_flex_b);
   assign lane_sample[2] = SAMPLE_BITS'(req_data.sample_stretch_a);
   assign lane_sample[3] = SAMPLE_BITS'(req_data.sample_stretch_b);

   for (genvar g = 0; g < sfse_pkg::CHANNELS; g++) begin : g_lane
      sfse_lane #(
         .WINDOW     (WINDOW),
         .SAMPLE_BITS(SAMPLE_BITS)
      ) u_lane (
         .clock (clock),
         .reset (reset),
         .ctrl  (lane_ctrl),
         .sample(lane_sample[g]),
         .avg   (lane_avg[g]),
         .zero  (lane_zero[g]),
         .busy  (lane_busy[g])
      );
   end

   sfse_merge #(
      .SAMPLE_BITS(SAMPLE_BITS)
   ) u_merge (
      .clock (clock),
      .reset (reset),
      .start (merge_start),
      .cfg   (cfg_ff),
      .avg   (lane_avg),
      .zero  (lane_zero),
      .done  (merge_done),
      .result(merge_result)
   );

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            sfse_pkg::CSR_FULL_SCALE: cfg_in.stretch_full_scale = csr_wdata;
            sfse_pkg::CSR_YELLOW:     cfg_in.yellow_threshold   = csr_wdata[9:0];
            sfse_pkg::CSR_RED:        cfg_in.red_threshold      = csr_wdata[9:0];
            sfse_pkg::CSR_SPAN:       cfg_in.span_length_cm     = csr_wdata[7:0];
            sfse_pkg::CSR_GAIN_A:     cfg_in.gain_a_tenths      = csr_wdata[7:0];
            sfse_pkg::CSR_GAIN_B:     cfg_in.gain_b_tenths      = csr_wdata[7:0];
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_comb begin
      lane_ctrl.sample_rd    = 1'b0;
      lane_ctrl.sample_upd   = (state_ff == S_SAMPLE);
      lane_ctrl.avg_start    = 1'b0;
      lane_ctrl.zero_capture = 1'b0;
      merge_start            = 1'b0;
      rsp_valid_in           = rsp_valid_ff && !rsp_ready;
      rsp_data_in            = rsp_data_ff;
      state_in               = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               unique case (req_data.mode)
                  sfse_pkg::MODE_SAMPLE: begin
                     lane_ctrl.sample_rd = 1'b1;
                     state_in            = S_SAMPLE;
                  end
                  sfse_pkg::MODE_ZERO: begin
                     lane_ctrl.zero_capture = 1'b1;
                  end
                  sfse_pkg::MODE_EVAL: begin
                     lane_ctrl.avg_start = 1'b1;
                     state_in            = S_AVG;
                  end
                  default: begin
                     state_in = S_IDLE;
                  end
               endcase
            end
         end
         S_SAMPLE: begin
            state_in = S_IDLE;
         end
         S_AVG: begin
            if (lane_busy == '0) begin
               merge_start = 1'b1;
               state_in    = S_MERGE;
            end
         end
         S_MERGE: begin
            if (merge_done) begin
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = merge_result;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff                  <= S_IDLE;
         rsp_valid_ff              <= 1'b0;
         cfg_ff.stretch_full_scale <= 12'd600;
         cfg_ff.yellow_threshold   <= 10'd10;
         cfg_ff.red_threshold      <= 10'd20;
         cfg_ff.span_length_cm     <= 8'd18;
         cfg_ff.gain_a_tenths      <= 8'd19;
         cfg_ff.gain_b_tenths      <= 8'd6;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         cfg_ff       <= cfg_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign out_stalled = (state_ff == S_OUT) && rsp_valid_ff && !rsp_ready;

   `SFSE_ASSERT_SAME(a_merge_done_in_merge, clock, reset, merge_done, state_ff == S_MERGE)
   `SFSE_ASSERT_SAME(a_lane_busy_in_avg, clock, reset, lane_busy[0], state_ff == S_AVG)
   `SFSE_ASSERT_NEXT(a_out_waits_on_stall, clock, reset, out_stalled, state_ff == S_OUT)

endmodule

`default_nettype wire

FILE: rtl/sfse_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sfse_ram #(
   parameter int WIDTH = 10,
   parameter int DEPTH = 8
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end

endmodule

`default_nettype wire

FILE: rtl/sfse_lane.sv
// ----------------------------------------------------------------------------
// Sensor channel lane
// Sample window with running sum, reciprocal-multiply average and zero register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sfse_lane #(
   parameter int WINDOW      = 8,
   parameter int SAMPLE_BITS = 10
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire sfse_pkg::lane_ctrl_type   ctrl,
   input  wire logic [SAMPLE_BITS-1:0]    sample,
   output logic      [SAMPLE_BITS-1:0]    avg,
   output logic      [SAMPLE_BITS-1:0]    zero,
   output logic                           busy
);

   localparam int PW   = $clog2(WINDOW);
   localparam int FILW = $clog2(WINDOW + 1);
   localparam int SUMW = SAMPLE_BITS + PW;
   localparam int SH   = SUMW + PW;
   localparam int RW   = SUMW + 1;
   localparam logic [RW-1:0]     RECIP    =
      RW'(((longint'(1) << SH) + longint'(WINDOW) - 1) / longint'(WINDOW));
   localparam logic [PW-1:0]     PTR_LAST = PW'(WINDOW - 1);
   localparam logic [FILW-1:0]   FILL_MAX = FILW'(WINDOW);

   logic [PW-1:0]          wptr_ff, wptr_in;
   logic [FILW-1:0]        fill_ff, fill_in;
   logic [SUMW-1:0]        sum_ff, sum_in;
   logic [SAMPLE_BITS-1:0] new_ff, new_in;
   logic                   busy_ff, busy_in;
   logic [SAMPLE_BITS-1:0] avg_ff, avg_in;
   logic [SAMPLE_BITS-1:0] zero_ff, zero_in;
   logic [SAMPLE_BITS-1:0] old_data;
   logic [SAMPLE_BITS-1:0] old_used;
   logic [SUMW+RW-1:0]     avg_prod;

   sfse_ram #(
      .WIDTH(SAMPLE_BITS),
      .DEPTH(WINDOW)
   ) u_window (
      .clock(clock),
      .we   (ctrl.sample_upd),
      .waddr(wptr_ff),
      .wdata(new_ff),
      .raddr(wptr_ff),
      .rdata(old_data)
   );

   always_comb begin
      wptr_in  = wptr_ff;
      fill_in  = fill_ff;
      sum_in   = sum_ff;
      new_in   = new_ff;
      busy_in  = busy_ff;
      avg_in   = avg_ff;
      zero_in  = zero_ff;
      old_used = (fill_ff == FILL_MAX) ? old_data : '0;
      avg_prod = {{RW{1'b0}}, sum_ff} * {{SUMW{1'b0}}, RECIP};
      if (ctrl.sample_rd) begin
         new_in = sample;
      end
      if (ctrl.sample_upd) begin
         sum_in  = sum_ff - SUMW'(old_used) + SUMW'(new_ff);
         wptr_in = (wptr_ff == PTR_LAST) ? '0 : wptr_ff + 1'b1;
         if (fill_ff != FILL_MAX) begin
            fill_in = fill_ff + 1'b1;
         end
      end
      if (ctrl.zero_capture) begin
         zero_in = avg_ff;
      end
      if (ctrl.avg_start) begin
         busy_in = 1'b1;
      end else if (busy_ff) begin
         busy_in = 1'b0;
         avg_in  = avg_prod[SH +: SAMPLE_BITS];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= '0;
         fill_ff <= '0;
         sum_ff  <= '0;
         busy_ff <= 1'b0;
         avg_ff  <= '0;
         zero_ff <= '0;
      end else begin
         wptr_ff <= wptr_in;
         fill_ff <= fill_in;
         sum_ff  <= sum_in;
         busy_ff <= busy_in;
         avg_ff  <= avg_in;
         zero_ff <= zero_in;
      end
      new_ff <= new_in;
   end

   assign avg  = avg_ff;
   assign zero = zero_ff;
   assign busy = busy_ff;

endmodule

`default_nettype wire

FILE: rtl/sfse_div.sv
// ----------------------------------------------------------------------------
// Sequential divider
// Unsigned restoring divider producing one quotient bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sfse_div (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           start,
   input  wire logic [sfse_pkg::DIV_NUM_W-1:0] num,
   input  wire logic [sfse_pkg::DIV_DEN_W-1:0] den,
   output logic                                busy,
   output logic      [sfse_pkg::DIV_NUM_W-1:0] quot
);

   localparam int NW = sfse_pkg::DIV_NUM_W;
   localparam int DW = sfse_pkg::DIV_DEN_W;
   localparam int CW = sfse_pkg::DIV_CNT_W;

   logic [DW-1:0] rem_ff, rem_in;
   logic [DW-1:0] den_ff, den_in;
   logic [NW-1:0] q_ff, q_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          busy_ff, busy_in;
   logic [DW:0]   trial;
   logic          ge;

   always_comb begin
      rem_in  = rem_ff;
      den_in  = den_ff;
      q_in    = q_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      trial   = {rem_ff, q_ff[NW-1]};
      ge      = trial >= {1'b0, den_ff};
      if (start) begin
         rem_in  = '0;
         den_in  = den;
         q_in    = num;
         cnt_in  = CW'(NW);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = ge ? DW'(trial - {1'b0, den_ff}) : trial[DW-1:0];
         q_in   = {q_ff[NW-2:0], ge};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
      end
      rem_ff <= rem_in;
      den_ff <= den_in;
      q_ff   <= q_in;
   end

   assign busy = busy_ff;
   assign quot = q_ff;

endmodule

`default_nettype wire

FILE: rtl/sfse_merge.sv
// ----------------------------------------------------------------------------
// Lane merge stage
// Combines lane averages into stretch percent, load level, location and depth.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sfse_merge #(
   parameter int SAMPLE_BITS = 10
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   start,
   input  wire sfse_pkg::cfg_type      cfg,
   input  wire logic [SAMPLE_BITS-1:0] avg  [sfse_pkg::CHANNELS],
   input  wire logic [SAMPLE_BITS-1:0] zero [sfse_pkg::CHANNELS],
   output logic                        done,
   output sfse_pkg::rsp_type           result
);

   localparam int DW = SAMPLE_BITS + 1;
   localparam int AW = SAMPLE_BITS + 10;
   localparam int FW = ((SAMPLE_BITS > 12) ? SAMPLE_BITS : 12) + 1;
   localparam int PW = SAMPLE_BITS + 9;
   localparam int QW = PW - 1;
   localparam logic signed [AW-1:0] ANG_MAX = AW'(450);
   localparam logic signed [PW-1:0] PCT_HI  = PW'(32767);
   localparam logic signed [PW-1:0] PCT_LO  = PW'(-32768);

   typedef enum logic [6:0] {
      M_IDLE = 7'b0000001,
      M_ANG  = 7'b0000010,
      M_TAN  = 7'b0000100,
      M_PCT  = 7'b0001000,
      M_SQ   = 7'b0010000,
      M_LOC  = 7'b0100000,
      M_DEP  = 7'b1000000
   } mstate_type;

   mstate_type             state_ff, state_in;
   logic signed [DW-1:0]   diff_ff [sfse_pkg::CHANNELS];
   logic signed [DW-1:0]   diff_in [sfse_pkg::CHANNELS];
   logic signed [DW-1:0]   stretch_ff, stretch_in;
   logic signed [FW-1:0]   divisor_ff, divisor_in;
   logic signed [AW-1:0]   ang_a_ff, ang_a_in, ang_b_ff, ang_b_in;
   logic [9:0]             ta_ff, ta_in, tb_ff, tb_in;
   logic                   zang_ff, zang_in, bad_ff, bad_in;
   logic [15:0]            pct_ff, pct_in;
   logic [1:0]             level_ff, level_in;
   logic [15:0]            loc_ff, loc_in;
   logic [19:0]            sq_ff, sq_in;
   sfse_pkg::rsp_type      result_ff, result_in;
   logic                   done_ff, done_in;

   logic [DW:0]            ssum;
   logic [SAMPLE_BITS:0]   zsum;
   logic [DW-1:0]          stretch_mag;
   logic [FW-1:0]          divisor_mag;
   logic [16:0]            prod_a, prod_b;
   logic [19:0]            sq_a, sq_b;
   logic [17:0]            loc_prod;
   logic [27:0]            dep_prod;
   logic [10:0]            tsum;
   logic [QW-1:0]          pct_q;
   logic signed [PW-1:0]   pct_s;
   logic                   neg, ok, fault;
   logic                   div_start, div_busy;
   logic [sfse_pkg::DIV_NUM_W-1:0] div_num, div_quot;
   logic [sfse_pkg::DIV_DEN_W-1:0] div_den;

   sfse_div u_div (
      .clock(clock),
      .reset(reset),
      .start(div_start),
      .num  (div_num),
      .den  (div_den),
      .busy (div_busy),
      .quot (div_quot)
   );

   always_comb begin
      for (int c = 0; c < sfse_pkg::CHANNELS; c++) begin
         diff_in[c] = $signed({1'b0, avg[c]}) - $signed({1'b0, zero[c]});
      end
      ssum        = {diff_in[2][DW-1], diff_in[2]} + {diff_in[3][DW-1], diff_in[3]};
      stretch_in  = ssum[DW:1];
      zsum        = {1'b0, zero[2]} + {1'b0, zero[3]};
      divisor_in  = $signed({{(FW - 12){1'b0}}, cfg.stretch_full_scale})
                  - $signed({{(FW - SAMPLE_BITS){1'b0}}, zsum[SAMPLE_BITS:1]});
      stretch_mag = stretch_ff[DW-1] ? (~stretch_ff + 1'b1) : stretch_ff;
      divisor_mag = divisor_ff[FW-1] ? (~divisor_ff + 1'b1) : divisor_ff;
      ang_a_in    = $signed({1'b0, cfg.gain_a_tenths}) * diff_ff[0];
      ang_b_in    = $signed({1'b0, cfg.gain_b_tenths}) * diff_ff[1];
      prod_a      = ang_a_ff[8:0] * 8'd205;
      prod_b      = ang_b_ff[8:0] * 8'd205;
      ta_in       = sfse_pkg::tan_lookup(prod_a[16:11]);
      tb_in       = sfse_pkg::tan_lookup(prod_b[16:11]);
      zang_in     = (ang_a_ff == '0) || (ang_b_ff == '0);
      bad_in      = ang_a_ff[AW-1] || ang_b_ff[AW-1]
                  || (ang_a_ff > ANG_MAX) || (ang_b_ff > ANG_MAX);
      sq_a        = ta_ff * ta_ff;
      sq_b        = tb_ff * tb_ff;
      sq_in       = sq_a + sq_b;
      tsum        = {1'b0, ta_ff} + {1'b0, tb_ff};
      loc_prod    = cfg.span_length_cm * ta_ff;
      dep_prod    = cfg.span_length_cm * sq_ff;
      pct_q       = div_quot[QW-1:0];
      neg         = stretch_ff[DW-1] ^ divisor_ff[FW-1];
      pct_s       = neg ? -$signed({1'b0, pct_q}) : $signed({1'b0, pct_q});
      ok          = !zang_ff && !bad_ff && (tsum != '0);
      fault       = !zang_ff && (bad_ff || (tsum == '0));

      if (divisor_ff == '0) begin
         pct_in   = stretch_ff[DW-1] ? sfse_pkg::PERCENT_MIN : sfse_pkg::PERCENT_MAX;
         level_in = sfse_pkg::LEVEL_RED;
      end else begin
         priority if (pct_s < $signed(PW'(cfg.yellow_threshold))) begin
            level_in = sfse_pkg::LEVEL_GREEN;
         end else if (pct_s < $signed(PW'(cfg.red_threshold))) begin
            level_in = sfse_pkg::LEVEL_YELLOW;
         end else begin
            level_in = sfse_pkg::LEVEL_RED;
         end
         priority if (pct_s > PCT_HI) begin
            pct_in = sfse_pkg::PERCENT_MAX;
         end else if (pct_s < PCT_LO) begin
            pct_in = sfse_pkg::PERCENT_MIN;
         end else begin
            pct_in = pct_s[15:0];
         end
      end

      loc_in                     = div_quot[15:0];
      result_in.location_q8      = ok ? loc_ff : '0;
      result_in.depth_q8         = ok ? div_quot[13:0] : '0;
      result_in.stretch_percent  = pct_ff;
      result_in.load_level       = level_ff;
      result_in.angle_fault      = fault;

      div_start = 1'b0;
      div_num   = {7'b0, dep_prod[27:3]};
      div_den   = {5'b0, tsum};
      done_in   = 1'b0;
      state_in  = state_ff;
      unique case (state_ff)
         M_IDLE: begin
            if (start) begin
               state_in = M_ANG;
            end
         end
         M_ANG: begin
            div_start = 1'b1;
            div_num   = sfse_pkg::DIV_NUM_W'(stretch_mag) * 32'd100;
            div_den   = sfse_pkg::DIV_DEN_W'(divisor_mag);
            state_in  = M_TAN;
         end
         M_TAN: begin
            state_in = M_PCT;
         end
         M_PCT: begin
            if (!div_busy) begin
               state_in = M_SQ;
            end
         end
         M_SQ: begin
            div_start = 1'b1;
            div_num   = {6'b0, loc_prod, 8'b0};
            state_in  = M_LOC;
         end
         M_LOC: begin
            if (!div_busy) begin
               div_start = 1'b1;
               state_in  = M_DEP;
            end
         end
         M_DEP: begin
            if (!div_busy) begin
               done_in  = 1'b1;
               state_in = M_IDLE;
            end
         end
         default: begin
            state_in = M_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= M_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      if (state_ff == M_IDLE && start) begin
         diff_ff    <= diff_in;
         stretch_ff <= stretch_in;
         divisor_ff <= divisor_in;
      end
      if (state_ff == M_ANG) begin
         ang_a_ff <= ang_a_in;
         ang_b_ff <= ang_b_in;
      end
      if (state_ff == M_TAN) begin
         ta_ff   <= ta_in;
         tb_ff   <= tb_in;
         zang_ff <= zang_in;
         bad_ff  <= bad_in;
      end
      if (state_ff == M_PCT && !div_busy) begin
         pct_ff   <= pct_in;
         level_ff <= level_in;
      end
      if (state_ff == M_SQ) begin
         sq_ff <= sq_in;
      end
      if (state_ff == M_LOC && !div_busy) begin
         loc_ff <= loc_in;
      end
      if (state_ff == M_DEP && !div_busy) begin
         result_ff <= result_in;
      end
   end

   assign done   = done_ff;
   assign result = result_ff;

endmodule

`default_nettype wire

FILE: tb/sv/tb_strain_flex_sensor_evaluator.sv
// ----------------------------------------------------------------------------
// Strain flex sensor evaluator testbench
// Drives sample, zero capture and evaluate transactions through the request
// channel and checks every response against a cycle-free software model of
// the sliding windows, zero registers, percent division and tangent lookup.
// Directed cases cover the field extremes and the fault and saturation paths,
// followed by random window sequences under varying configuration and idling.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_strain_flex_sensor_evaluator;
   import sfse_pkg::*;

   localparam int WIN = 8;
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 3'd7;
   localparam logic [1:0] MODE_UNUSED = 2'd3;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   req_type req_data = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   rsp_type rsp_data;
   logic csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   strain_flex_sensor_evaluator i_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always #5 clock = ~clock;

   // Model state of the block.
   cfg_type sensor_cfg;
   int window_samples [CHANNELS][WIN];
   int window_slot;
   int lane_average [CHANNELS];
   int lane_zero [CHANNELS];
   rsp_type pending_readings [$];

   int error_count = 0;
   int items_sent = 0;
   int tx_idle_pct = 0;
   int rx_idle_pct = 0;
   int rx_hold_cycles = 0;

   always @(negedge clock) begin
      if (rx_hold_cycles > 0) begin
         rsp_ready <= 1'b0;
         rx_hold_cycles = rx_hold_cycles - 1;
      end else begin
         rsp_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
      end
   end

   function automatic void evaluate_reading();
      longint diff [CHANNELS];
      longint sum, stretch, szero, divisor, pct, ang_a, ang_b, ta, tb, span, tsum;
      rsp_type r;
      r = '0;
      for (int c = 0; c < CHANNELS; c++) begin
         sum = 0;
         for (int k = 0; k < WIN; k++) sum += window_samples[c][k];
         lane_average[c] = int'(sum / WIN);
         diff[c] = longint'(lane_average[c]) - longint'(lane_zero[c]);
      end
      stretch = (diff[2] + diff[3]) >>> 1;
      szero = (longint'(lane_zero[2]) + longint'(lane_zero[3])) >>> 1;
      divisor = longint'(sensor_cfg.stretch_full_scale) - szero;
      if (divisor == 0) begin
         pct = (stretch >= 0) ? 32767 : -32768;
         r.load_level = LEVEL_RED;
      end else begin
         pct = (100 * stretch) / divisor;
         if (pct < longint'(sensor_cfg.yellow_threshold)) r.load_level = LEVEL_GREEN;
         else if (pct < longint'(sensor_cfg.red_threshold)) r.load_level = LEVEL_YELLOW;
         else r.load_level = LEVEL_RED;
         if (pct > 32767) pct = 32767;
         if (pct < -32768) pct = -32768;
      end
      r.stretch_percent = pct[15:0];
      ang_a = longint'(sensor_cfg.gain_a_tenths) * diff[0];
      ang_b = longint'(sensor_cfg.gain_b_tenths) * diff[1];
      if (ang_a != 0 && ang_b != 0) begin
         if (ang_a < 0 || ang_b < 0 || ang_a > 450 || ang_b > 450) begin
            r.angle_fault = 1'b1;
         end else begin
            ta = TAN512[ang_a / 10];
            tb = TAN512[ang_b / 10];
            tsum = ta + tb;
            if (tsum == 0) begin
               r.angle_fault = 1'b1;
            end else begin
               span = longint'(sensor_cfg.span_length_cm) * 256;
               r.location_q8 = 16'((span * ta) / tsum);
               r.depth_q8 = 14'((span * (ta * ta + tb * tb)) / (tsum * 2048));
            end
         end
      end
      pending_readings.push_back(r);
   endfunction

   function automatic void apply_request(input req_type r);
      case (r.mode)
         MODE_SAMPLE: begin
            window_slot = (window_slot + 1) % WIN;
            window_samples[0][window_slot] = r.sample_flex_a;
            window_samples[1][window_slot] = r.sample_flex_b;
            window_samples[2][window_slot] = r.sample_stretch_a;
            window_samples[3][window_slot] = r.sample_stretch_b;
         end
         MODE_ZERO: begin
            for (int c = 0; c < CHANNELS; c++) lane_zero[c] = lane_average[c];
         end
         MODE_EVAL: evaluate_reading();
         default: ;
      endcase
   endfunction

   function automatic void check_field(input string name, input longint exp_v,
                                       input longint act_v);
      if (exp_v != act_v) begin
         $display("%0t: mismatch on %s, expected %0d, actual %0d", $time, name, exp_v,
                  act_v);
         error_count++;
      end
   endfunction

   always @(posedge clock) begin
      rsp_type exp_r;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_readings.size() == 0) begin
            $display("%0t: unexpected response transaction, expected none, actual %h",
                     $time, rsp_data);
            error_count++;
         end else begin
            exp_r = pending_readings.pop_front();
            check_field("location_q8", exp_r.location_q8, rsp_data.location_q8);
            check_field("depth_q8", exp_r.depth_q8, rsp_data.depth_q8);
            check_field("stretch_percent", exp_r.stretch_percent,
                        rsp_data.stretch_percent);
            check_field("load_level", exp_r.load_level, rsp_data.load_level);
            check_field("angle_fault", exp_r.angle_fault, rsp_data.angle_fault);
         end
      end
   end

   task automatic send_item(input req_type r);
      @(negedge clock);
      while ($urandom_range(0, 99) < tx_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data <= r;
      forever begin
         @(posedge clock);
         if (req_ready) break;
      end
      apply_request(r);
      items_sent++;
   endtask

   task automatic send_mode(input logic [1:0] mode);
      req_type r;
      r = '0;
      r.mode = mode;
      send_item(r);
   endtask

   task automatic send_sample(input int fa, input int fb, input int sa, input int sb);
      req_type r;
      r.mode = MODE_SAMPLE;
      r.sample_flex_a = fa[9:0];
      r.sample_flex_b = fb[9:0];
      r.sample_stretch_a = sa[9:0];
      r.sample_stretch_b = sb[9:0];
      send_item(r);
   endtask

   task automatic fill_window(input int fa, input int fb, input int sa, input int sb);
      for (int k = 0; k < WIN; k++) send_sample(fa, fb, sa, sb);
   endtask

   task automatic wait_drained();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_readings.size() != 0) @(posedge clock);
      repeat (130) @(posedge clock);
   endtask

   task automatic apply_config(input cfg_type c);
      logic [CSR_DATA_W-1:0] vals [6];
      wait_drained();
      vals[0] = c.stretch_full_scale;
      vals[1] = CSR_DATA_W'(c.yellow_threshold);
      vals[2] = CSR_DATA_W'(c.red_threshold);
      vals[3] = CSR_DATA_W'(c.span_length_cm);
      vals[4] = CSR_DATA_W'(c.gain_a_tenths);
      vals[5] = CSR_DATA_W'(c.gain_b_tenths);
      for (int i = 0; i <= int'(CSR_GAIN_B); i++) begin
         @(negedge clock);
         csr_we <= 1'b1;
         csr_index <= CSR_IDX_W'(i);
         csr_wdata <= vals[i];
      end
      @(negedge clock);
      csr_index <= CSR_UNUSED;
      csr_wdata <= CSR_DATA_W'($urandom);
      @(negedge clock);
      csr_we <= 1'b0;
      sensor_cfg = c;
   endtask

   function automatic cfg_type random_config();
      cfg_type c;
      c.stretch_full_scale = 12'($urandom_range(0, 4095));
      c.yellow_threshold = 10'($urandom_range(0, 60));
      c.red_threshold = 10'(c.yellow_threshold + $urandom_range(0, 60));
      if ($urandom_range(0, 7) == 0) begin
         c.yellow_threshold = 10'($urandom);
         c.red_threshold = 10'($urandom);
      end
      c.span_length_cm = 8'($urandom);
      c.gain_a_tenths = 8'($urandom_range(1, 40));
      c.gain_b_tenths = 8'($urandom_range(1, 40));
      if ($urandom_range(0, 5) == 0) c.gain_a_tenths = 8'($urandom);
      if ($urandom_range(0, 5) == 0) c.gain_b_tenths = 8'($urandom);
      return c;
   endfunction

   function automatic int near_value(input int base, input int spread);
      int v;
      v = ($urandom_range(0, 4) == 0) ? base - int'($urandom_range(0, spread))
                                      : base + int'($urandom_range(0, spread));
      if (v < 0) v = 0;
      if (v > 1023) v = 1023;
      return v;
   endfunction

   task automatic send_noisy_sample(input int b [CHANNELS], input int spread);
      req_type r;
      if ($urandom_range(0, 11) == 0) begin
         r = req_type'($urandom_range(0, 3) << 40 | {$urandom, $urandom});
         send_item(r);
      end else begin
         send_sample(near_value(b[0], spread), near_value(b[1], spread),
                     near_value(b[2], spread), near_value(b[3], spread));
      end
   endtask

   task automatic run_window_sequence();
      int base [CHANNELS];
      int spread;
      cfg_type c;
      if ($urandom_range(0, 5) == 0) apply_config(random_config());
      foreach (base[i]) base[i] = $urandom_range(0, 1023);
      for (int k = 0; k < WIN; k++) send_noisy_sample(base, 0);
      send_mode(MODE_EVAL);
      send_mode(MODE_ZERO);
      if ($urandom_range(0, 7) == 0) begin
         c = sensor_cfg;
         c.stretch_full_scale = 12'((lane_zero[2] + lane_zero[3]) >> 1);
         apply_config(c);
      end
      spread = $urandom_range(0, 48);
      repeat ($urandom_range(1, 4)) begin
         repeat ($urandom_range(1, WIN)) send_noisy_sample(base, spread);
         send_mode(MODE_EVAL);
      end
   endtask

   task automatic test_special_cases();
      cfg_type c;
      // Empty windows: zero angles, zero percent.
      send_mode(MODE_EVAL);
      // Full scale samples: angles over 45 degrees, red load.
      fill_window(1023, 1023, 1023, 1023);
      send_mode(MODE_EVAL);
      send_mode(MODE_UNUSED);
      send_mode(MODE_ZERO);
      // Divisor of zero with a non-negative stretch.
      c = sensor_cfg;
      c.stretch_full_scale = 12'd1023;
      apply_config(c);
      send_mode(MODE_EVAL);
      // Negative angles and negative stretch against a zero divisor.
      fill_window(0, 0, 0, 0);
      send_mode(MODE_EVAL);
      send_mode(MODE_ZERO);
      // Angles under one degree give a zero tangent sum; percent saturates.
      c.stretch_full_scale = 12'd1;
      c.gain_a_tenths = 8'd1;
      c.gain_b_tenths = 8'd1;
      apply_config(c);
      send_sample(8, 8, 1023, 1023);
      send_mode(MODE_EVAL);
      send_sample(8, 8, 1023, 1023);
      send_sample(8, 8, 1023, 1023);
      send_mode(MODE_EVAL);
      // A valid span location and depth.
      c.gain_a_tenths = 8'd150;
      c.gain_b_tenths = 8'd100;
      c.stretch_full_scale = 12'd4095;
      apply_config(c);
      send_mode(MODE_EVAL);
   endtask

   task automatic test_config_extremes();
      cfg_type c;
      c = '1;
      apply_config(c);
      repeat (2) run_window_sequence();
      c = '0;
      apply_config(c);
      repeat (2) run_window_sequence();
   endtask

   task automatic test_random_traffic(input int tx_pct, input int rx_pct, input int count);
      int stop_at;
      tx_idle_pct = tx_pct;
      rx_idle_pct = rx_pct;
      stop_at = items_sent + count;
      while (items_sent < stop_at) run_window_sequence();
   endtask

   task automatic test_backpressure();
      int base [CHANNELS];
      tx_idle_pct = 0;
      rx_idle_pct = 0;
      apply_config(random_config());
      foreach (base[i]) base[i] = $urandom_range(100, 900);
      rx_hold_cycles = 900;
      for (int k = 0; k < 6; k++) begin
         send_noisy_sample(base, 20);
         send_mode(MODE_EVAL);
      end
      wait_drained();
      for (int k = 0; k < 4; k++) begin
         send_noisy_sample(base, 20);
         send_mode(MODE_EVAL);
      end
   endtask

   initial begin
      sensor_cfg.stretch_full_scale = 12'd600;
      sensor_cfg.yellow_threshold = 10'd10;
      sensor_cfg.red_threshold = 10'd20;
      sensor_cfg.span_length_cm = 8'd18;
      sensor_cfg.gain_a_tenths = 8'd19;
      sensor_cfg.gain_b_tenths = 8'd6;
      window_slot = WIN - 1;
      foreach (window_samples[c, k]) window_samples[c][k] = 0;
      foreach (lane_average[c]) begin
         lane_average[c] = 0;
         lane_zero[c] = 0;
      end
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_special_cases();
      test_config_extremes();
      test_random_traffic(27, 55, 400);
      test_backpressure();
      test_random_traffic(55, 27, 400);
      test_random_traffic(0, 0, 400);
      wait_drained();

      if (error_count == 0) begin
         $display("tb_strain_flex_sensor_evaluator OK");
      end else begin
         $display("tb_strain_flex_sensor_evaluator NOT OK");
      end
      $finish;
   end

   initial begin
      #30_000_000;
      $display("tb_strain_flex_sensor_evaluator NOT OK");
      $finish;
   end

endmodule
